@@ hdl/icst_pkg.sv @@
// icst_pkg: shared constants, state encoding and controller/datapath bundles
// for the inversion counter segment tree core; no dependencies
`timescale 1ns / 1ps

package icst_pkg;

  // default sizing of the tree
  localparam int VALUES_DEF     = 1024;
  localparam int COUNT_BITS_DEF = 16;

  // fixed field widths of the transaction ports
  localparam int VALUE_W = 10;
  localparam int SMALL_W = 16;
  localparam int TOTAL_W = 31;

  // operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  // controller states
  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_WIPE,
    ST_REJ,
    ST_LEAF_RD,
    ST_LEAF_WR,
    ST_UP,
    ST_QRY,
    ST_FIN
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic wipe_init;
    logic clr_step;
    logic leaf_rd;
    logic leaf_wr;
    logic up_step;
    logic qry_step;
    logic emit_ins;
    logic emit_rej;
    logic emit_zero;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic full;
    logic clr_last;
    logic up_last;
    logic q_more;
  } stat_t;

endpackage

@@ hdl/icst_ctrl.sv @@
// icst_ctrl: sequencing state machine for the inversion counter core
// depends on icst_pkg
`timescale 1ns / 1ps

module icst_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            op,
  input  icst_pkg::stat_t stat,
  output icst_pkg::cmd_t  cmd,
  output logic            busy
);
  import icst_pkg::*;

  state_t state;
  state_t state_next;

  // state register, reset starts the clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    cmd        = '0;
    busy       = 1'b1;
    state_next = state;
    case (state)
      ST_INIT: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load = 1'b1;
          if (op == OP_CLEAR) begin
            cmd.wipe_init = 1'b1;
            state_next    = ST_WIPE;
          end else if (stat.full) begin
            state_next = ST_REJ;
          end else begin
            state_next = ST_LEAF_RD;
          end
        end
      end
      ST_WIPE: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          cmd.emit_zero = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      ST_REJ: begin
        cmd.emit_rej = 1'b1;
        state_next   = ST_IDLE;
      end
      ST_LEAF_RD: begin
        cmd.leaf_rd = 1'b1;
        state_next  = ST_LEAF_WR;
      end
      ST_LEAF_WR: begin
        cmd.leaf_wr = 1'b1;
        state_next  = ST_UP;
      end
      ST_UP: begin
        cmd.up_step = 1'b1;
        if (stat.up_last) begin
          state_next = ST_QRY;
        end
      end
      ST_QRY: begin
        cmd.qry_step = 1'b1;
        if (!stat.q_more) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd.emit_ins = 1'b1;
        state_next   = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ hdl/icst_dp.sv @@
// icst_dp: tree memory, update walk, prefix query, running total and
// result registers; depends on icst_pkg
`timescale 1ns / 1ps

module icst_dp #(
  parameter int VALUES     = icst_pkg::VALUES_DEF,
  parameter int COUNT_BITS = icst_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  icst_pkg::cmd_t                cmd,
  input  logic [icst_pkg::VALUE_W-1:0]  value,
  output icst_pkg::stat_t               stat,
  output logic                          done,
  output logic [icst_pkg::SMALL_W-1:0]  smaller_count,
  output logic [icst_pkg::TOTAL_W-1:0]  total,
  output logic                          rejected
);
  import icst_pkg::*;

  localparam int DEPTH  = 2 * VALUES;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CMP_W  = (ADDR_W > VALUE_W) ? ADDR_W : VALUE_W;
  localparam int SUM_W  = ((COUNT_BITS > TOTAL_W) ? COUNT_BITS : TOTAL_W) + 1;

  localparam logic [ADDR_W-1:0] LEAF_BASE = ADDR_W'(VALUES);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
  localparam logic [ADDR_W-1:0] ROOT      = ADDR_W'(1);
  localparam logic [CMP_W-1:0]  RANK_LIM  = CMP_W'(VALUES);
  localparam logic [CMP_W-1:0]  RANK_TOP  = CMP_W'(VALUES - 1);
  localparam logic [SUM_W-1:0]  TOTAL_MAX = {{(SUM_W - TOTAL_W){1'b0}}, {TOTAL_W{1'b1}}};

  // tree node store, node 1 is the root, leaves start at VALUES
  logic [COUNT_BITS-1:0] mem [DEPTH];
  logic [COUNT_BITS-1:0] rd_a;
  logic [COUNT_BITS-1:0] rd_b;
  logic [ADDR_W-1:0]     ra;
  logic [ADDR_W-1:0]     rb;
  logic                  we;
  logic [ADDR_W-1:0]     wa;
  logic [COUNT_BITS-1:0] wd;

  // walk and query registers
  logic [ADDR_W-1:0]     node;
  logic [ADDR_W-1:0]     lo;
  logic [ADDR_W-1:0]     hi;
  logic [COUNT_BITS-1:0] cur;
  logic [COUNT_BITS-1:0] acc;
  logic                  vld_a;
  logic                  vld_b;
  logic [ADDR_W-1:0]     clr_addr;
  logic [TOTAL_W-1:0]    total_r;
  logic [COUNT_BITS-1:0] items;

  logic [CMP_W-1:0]      value_ext;
  logic [CMP_W-1:0]      rank;
  logic [ADDR_W-1:0]     leaf;
  logic [ADDR_W-1:0]     parent;
  logic [ADDR_W-1:0]     lo_step;
  logic [ADDR_W-1:0]     hi_even;
  logic                  q_more;
  logic [COUNT_BITS-1:0] acc_next;
  logic [SUM_W-1:0]      sum_total;
  logic [TOTAL_W-1:0]    total_sat;

  // rank saturation and leaf address
  assign value_ext = CMP_W'(value);
  assign rank      = (value_ext >= RANK_LIM) ? RANK_TOP : value_ext;
  assign leaf      = LEAF_BASE + ADDR_W'(rank);

  // tree navigation
  assign parent  = {1'b0, node[ADDR_W-1:1]};
  assign lo_step = ADDR_W'(({1'b0, lo} + (ADDR_W + 1)'(lo[0])) >> 1);
  assign hi_even = {hi[ADDR_W-1:1], 1'b0};
  assign q_more  = lo < hi;

  // status to the controller
  assign stat.full     = &items;
  assign stat.clr_last = clr_addr == LAST_ADDR;
  assign stat.up_last  = parent == ROOT;
  assign stat.q_more   = q_more;

  // accumulate the node counts fetched by the query
  assign acc_next = acc + (vld_a ? rd_a : '0) + (vld_b ? rd_b : '0);

  // saturating running total
  assign sum_total = SUM_W'(total_r) + SUM_W'(acc);
  assign total_sat = (sum_total > TOTAL_MAX) ? TOTAL_W'(TOTAL_MAX) : sum_total[TOTAL_W-1:0];

  // write port select
  always_comb begin
    we = 1'b0;
    wa = clr_addr;
    wd = '0;
    if (cmd.clr_step) begin
      we = 1'b1;
    end else if (cmd.leaf_wr) begin
      we = 1'b1;
      wa = node;
      wd = rd_a + COUNT_BITS'(1);
    end else if (cmd.up_step) begin
      we = 1'b1;
      wa = parent;
      wd = cur + rd_b;
    end
  end

  // read port select
  always_comb begin
    ra = lo;
    rb = hi_even;
    if (cmd.leaf_rd) begin
      ra = node;
    end
    if (cmd.leaf_wr) begin
      rb = node ^ ROOT;
    end else if (cmd.up_step) begin
      rb = parent ^ ROOT;
    end
  end

  // node store, one write and two registered reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_a <= mem[ra];
    rd_b <= mem[rb];
  end

  // walk, query and accumulator registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      node <= leaf;
      lo   <= LEAF_BASE;
      hi   <= leaf;
      acc  <= '0;
    end else begin
      acc <= acc_next;
      if (cmd.leaf_wr) begin
        cur <= rd_a + COUNT_BITS'(1);
      end
      if (cmd.up_step) begin
        cur  <= cur + rd_b;
        node <= parent;
      end
      if (cmd.qry_step && q_more) begin
        lo <= lo_step;
        hi <= {1'b0, hi[ADDR_W-1:1]};
      end
    end
  end

  // control state: clear pointer, total, item count, fetch flags, strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      total_r  <= '0;
      items    <= '0;
      vld_a    <= 1'b0;
      vld_b    <= 1'b0;
      done     <= 1'b0;
    end else begin
      vld_a <= cmd.qry_step & q_more & lo[0];
      vld_b <= cmd.qry_step & q_more & hi[0];
      done  <= cmd.emit_ins | cmd.emit_rej | cmd.emit_zero;
      if (cmd.wipe_init) begin
        clr_addr <= '0;
        total_r  <= '0;
        items    <= '0;
      end else if (cmd.clr_step && !stat.clr_last) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      if (cmd.emit_ins) begin
        total_r <= total_sat;
        items   <= items + COUNT_BITS'(1);
      end
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.emit_ins) begin
      smaller_count <= SMALL_W'(acc);
      total         <= total_sat;
      rejected      <= 1'b0;
    end else if (cmd.emit_rej) begin
      smaller_count <= '0;
      total         <= total_r;
      rejected      <= 1'b1;
    end else if (cmd.emit_zero) begin
      smaller_count <= '0;
      total         <= '0;
      rejected      <= 1'b0;
    end
  end

endmodule

@@ hdl/inversion_counter_segment_tree_core.sv @@
// insert: a leaf read and a leaf write, then a walk up to the root writing one node per step,
// then the query steps, which climb one tree level each until the range is empty, and a finish
// step; the pace is set by the single write port and the two read ports of the tree store
// rejected insert: the reject state alone; clear: all 2*VALUES nodes, one node written per cycle
// the result strobe comes in the cycle after the last busy cycle and lasts one cycle
// reset (synchronous, active high) starts a clearing pass over the tree with busy held high
`timescale 1ns / 1ps

module inversion_counter_segment_tree_core #(
  parameter int VALUES     = icst_pkg::VALUES_DEF,
  parameter int COUNT_BITS = icst_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          op,
  input  logic [icst_pkg::VALUE_W-1:0]  value,
  output logic                          done,
  output logic [icst_pkg::SMALL_W-1:0]  smaller_count,
  output logic [icst_pkg::TOTAL_W-1:0]  total,
  output logic                          rejected
);
  import icst_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencer
  icst_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .op    (op),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // tree store and arithmetic
  icst_dp #(
    .VALUES     (VALUES),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .value         (value),
    .stat          (stat),
    .done          (done),
    .smaller_count (smaller_count),
    .total         (total),
    .rejected      (rejected)
  );

endmodule

@@ hdl/icst_checker.sv @@
// icst_checker: port level checks on the inversion counter core, bound to the top level
// depends on icst_pkg and inversion_counter_segment_tree_core
`timescale 1ns / 1ps

module icst_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          done,
  input logic [icst_pkg::SMALL_W-1:0]  smaller_count,
  input logic [icst_pkg::TOTAL_W-1:0]  total,
  input logic                          rejected
);

  // reset always leads into the clearing pass
  assert property (@(posedge clk) rst |=> busy)
    else $error("core not busy after reset");

  // a result is only shown once the core has gone idle
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  // no result directly after a transaction is taken
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> !done)
    else $error("result strobe right after accept");

  // a rejected insert reports no smaller items
  assert property (@(posedge clk) disable iff (rst)
    (done && rejected) |-> (smaller_count == '0))
    else $error("rejected result with nonzero count");

endmodule

bind inversion_counter_segment_tree_core icst_checker u_icst_checker (.*);

@@ tb/sv/tb.sv @@
// tb: self-checking bench for inversion_counter_segment_tree_core, with its own
// segment tree model predicting every result transaction not typed in by hand
// depends on icst_pkg and the core
`timescale 1ns / 1ps

module tb;

  import icst_pkg::*;

  localparam int RANKS      = VALUES_DEF;
  localparam int NODE_TOTAL = 2 * RANKS;
  localparam int CAPACITY   = (1 << COUNT_BITS_DEF) - 1;
  localparam int STALL_MAX  = 10000;
  localparam int DRAIN_WAIT = 40;
  localparam logic [31:0] TOTAL_SAT = 32'h7FFF_FFFF;

  typedef struct packed {
    logic [SMALL_W-1:0] smaller;
    logic [TOTAL_W-1:0] total;
    logic               rejected;
  } tally_t;

  typedef struct {
    logic               op;
    logic [VALUE_W-1:0] rank;
    bit                 typed;
    tally_t             want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  logic op;
  logic [VALUE_W-1:0] value;
  logic done;
  logic [SMALL_W-1:0] smaller_count;
  logic [TOTAL_W-1:0] total;
  logic rejected;

  // model state
  logic [COUNT_BITS_DEF-1:0] node_count [0:NODE_TOTAL-1];
  logic [31:0] sum_so_far;
  int unsigned inserts_kept;

  tally_t    pending_tallies[$];
  stim_row_t directed_rows[$];
  int        mismatches = 0;
  int        results_seen = 0;
  int        stall_cycles = 0;
  bit        no_idle = 1'b0;
  logic [VALUE_W-1:0] window_base;
  logic [VALUE_W-1:0] walk_rank;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  inversion_counter_segment_tree_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .op           (op),
    .value        (value),
    .done         (done),
    .smaller_count(smaller_count),
    .total        (total),
    .rejected     (rejected)
  );

  task automatic report_mismatch(input string msg);
    $display("mismatch at result %0d: %s", results_seen, msg);
    mismatches++;
  endtask

  // empty tree, zero total and item count
  task automatic wipe_tree();
    for (int n = 0; n < NODE_TOTAL; n++) node_count[n] = '0;
    sum_so_far   = '0;
    inserts_kept = 0;
  endtask

  // sum of the counts of ranks below limit
  function automatic logic [31:0] ranks_below(input int unsigned limit);
    int unsigned lo;
    int unsigned hi;
    logic [31:0] acc;
    lo  = RANKS;
    hi  = RANKS + limit;
    acc = '0;
    while (lo < hi) begin
      if (lo & 1) begin
        acc += node_count[lo];
        lo++;
      end
      if (hi & 1) begin
        hi--;
        acc += node_count[hi];
      end
      lo >>= 1;
      hi >>= 1;
    end
    return acc;
  endfunction

  // expected result of one transaction, state updated as the core should
  task automatic predict_tally(input logic op_i, input logic [VALUE_W-1:0] rank,
                               output tally_t res);
    int unsigned node;
    int unsigned r;
    logic [31:0] below;
    logic [32:0] grown;
    res = '0;
    if (op_i == OP_CLEAR) begin
      wipe_tree();
    end else if (inserts_kept >= CAPACITY) begin
      res.total    = sum_so_far[TOTAL_W-1:0];
      res.rejected = 1'b1;
    end else begin
      r = rank;
      if (r >= RANKS) r = RANKS - 1;
      node = RANKS + r;
      node_count[node] = node_count[node] + 1'b1;
      while (node > 1) begin
        node >>= 1;
        node_count[node] = node_count[2*node] + node_count[2*node+1];
      end
      inserts_kept++;
      below = ranks_below(r);
      grown = {1'b0, sum_so_far} + {1'b0, below};
      sum_so_far = (grown > {1'b0, TOTAL_SAT}) ? TOTAL_SAT : grown[31:0];
      res.smaller = below[SMALL_W-1:0];
      res.total   = sum_so_far[TOTAL_W-1:0];
    end
  endtask

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 80) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 15);
    return $urandom_range(20, 80);
  endfunction

  // rank drawn according to the style of the current phase
  function automatic logic [VALUE_W-1:0] pick_rank(input int style);
    case (style)
      0: return VALUE_W'($urandom_range(0, RANKS - 1));
      1: return window_base + VALUE_W'($urandom_range(0, 7));
      2: begin
        case ($urandom_range(0, 3))
          0: return '0;
          1: return VALUE_W'(RANKS - 1);
          2: return VALUE_W'(1);
          default: return VALUE_W'(RANKS - 2);
        endcase
      end
      default: begin
        walk_rank = walk_rank - VALUE_W'($urandom_range(0, 3));
        return walk_rank;
      end
    endcase
  endfunction

  // one transaction: idle gap with noise on the fields, then hold start until taken
  task automatic send(input logic op_i, input logic [VALUE_W-1:0] rank, input int gap,
                      input bit typed, input tally_t want);
    tally_t predicted;
    repeat (gap) begin
      start <= 1'b0;
      op    <= 1'($urandom);
      value <= VALUE_W'($urandom);
      @(posedge clk);
    end
    start <= 1'b1;
    op    <= op_i;
    value <= rank;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_tally(op_i, rank, predicted);
    pending_tallies = {pending_tallies, (typed ? want : predicted)};
  endtask

  // sender holds off until every outstanding result has come back
  task automatic wait_for_results();
    start <= 1'b0;
    while (pending_tallies.size() != 0) @(posedge clk);
  endtask

  task automatic add_row(input logic op_i, input logic [VALUE_W-1:0] rank, input bit typed,
                         input int s, input int t, input bit rj);
    stim_row_t row;
    row.op            = op_i;
    row.rank          = rank;
    row.typed         = typed;
    row.want.smaller  = SMALL_W'(s);
    row.want.total    = TOTAL_W'(t);
    row.want.rejected = rj;
    directed_rows = {directed_rows, row};
  endtask

  // compare each result transaction with the oldest expectation
  always @(posedge clk) begin : check_results
    tally_t want;
    if (!rst && done) begin
      if (pending_tallies.size() == 0) begin
        report_mismatch($sformatf("unexpected result smaller %0d total %0d rejected %0d",
                                  smaller_count, total, rejected));
      end else begin
        want = pending_tallies.pop_front();
        if (smaller_count !== want.smaller)
          report_mismatch($sformatf("smaller_count got %0d want %0d",
                                    smaller_count, want.smaller));
        if (total !== want.total)
          report_mismatch($sformatf("total got %0d want %0d", total, want.total));
        if (rejected !== want.rejected)
          report_mismatch($sformatf("rejected got %0d want %0d", rejected, want.rejected));
      end
      results_seen++;
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_MAX) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int style;
    rst   = 1'b1;
    start = 1'b0;
    op    = OP_INSERT;
    value = '0;
    wipe_tree();

    // directed rows, expectations typed in where obvious
    add_row(OP_INSERT, 10'd0,    1, 0, 0, 0);
    add_row(OP_INSERT, 10'd1023, 1, 1, 1, 0);
    add_row(OP_INSERT, 10'd512,  0, 0, 0, 0);
    add_row(OP_INSERT, 10'd512,  0, 0, 0, 0);
    add_row(OP_INSERT, 10'd511,  0, 0, 0, 0);
    add_row(OP_INSERT, 10'd1,    0, 0, 0, 0);
    add_row(OP_INSERT, 10'd0,    0, 0, 0, 0);
    add_row(OP_INSERT, 10'd1023, 0, 0, 0, 0);
    add_row(OP_CLEAR,  10'd1023, 1, 0, 0, 0);
    add_row(OP_INSERT, 10'd1023, 1, 0, 0, 0);
    add_row(OP_INSERT, 10'd1022, 0, 0, 0, 0);
    add_row(OP_INSERT, 10'd1023, 0, 0, 0, 0);
    add_row(OP_INSERT, 10'd0,    0, 0, 0, 0);
    add_row(OP_INSERT, 10'h155,  0, 0, 0, 0);
    add_row(OP_INSERT, 10'h2AA,  0, 0, 0, 0);
    add_row(OP_CLEAR,  10'h2AA,  1, 0, 0, 0);
    add_row(OP_CLEAR,  10'h155,  1, 0, 0, 0);
    add_row(OP_INSERT, 10'd5,    1, 0, 0, 0);
    add_row(OP_INSERT, 10'd4,    0, 0, 0, 0);
    add_row(OP_INSERT, 10'd6,    0, 0, 0, 0);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send(directed_rows[i].op, directed_rows[i].rank, pick_gap(), directed_rows[i].typed,
           directed_rows[i].want);
    wait_for_results();

    // clear, a short back to back burst at the extremes, clear again, then one insert at the top rank
    send(OP_CLEAR, '0, 0, 1, '0);
    for (int i = 0; i < 8; i++)
      send(OP_INSERT, (i % 3 == 2) ? 10'd1023 : 10'd0, 0, 0, '0);
    send(OP_CLEAR, '0, pick_gap(), 1, '0);
    send(OP_INSERT, 10'd1023, pick_gap(), 1, '0);
    wait_for_results();

    // random phases, the first four each with its own flavour of ranks, the rest one of these at random
    for (int phase = 0; phase < 6; phase++) begin
      style       = (phase < 4) ? phase : $urandom_range(0, 3);
      no_idle     = (phase == 2);
      window_base = VALUE_W'($urandom_range(0, RANKS - 8));
      walk_rank   = VALUE_W'(RANKS - 1);
      for (int k = 0; k < 200; k++) begin
        if ($urandom_range(0, 49) == 0)
          send(OP_CLEAR, VALUE_W'($urandom), pick_gap(), 0, '0);
        else
          send(OP_INSERT, pick_rank(style), pick_gap(), 0, '0);
      end
      if (phase % 2 == 1) wait_for_results();
    end

    wait_for_results();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
